FILE: rtl/fnvht_pkg.sv
package fnvht_pkg;

  // Table geometry; TABLE_SLOTS must be a power of two so the home slot is a bit-slice
  localparam int TABLE_SLOTS   = 64;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int CNT_W         = SLOT_W + 1;
  localparam int MAX_KEY_BYTES = 8;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 6;
  localparam int HASH_W  = 32;
  localparam int BYTE_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd48;

  // Slot RAM word for the key side: {length, key}
  localparam int SLOT_KEY_W = LEN_W + KEY_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    REQ_GET    = 2'd0,
    REQ_DEFINE = 2'd1,
    REQ_ASSIGN = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_ENTRY_LIMIT = 1'b0
  } reg_index_e;

  typedef enum logic [0:0] {
    F_IDLE,
    F_HASH
  } front_state_e;

  typedef enum logic [0:0] {
    B_IDLE,
    B_PROBE
  } back_state_e;

  // Classified request, as handed from the front end to the probe engine
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] home;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/fnvht_ram.sv
module fnvht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fnvht_front.sv
module fnvht_front import fnvht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   req_type_i,
  input  logic [KEY_W-1:0]  key_bytes_i,
  input  logic [LEN_W-1:0]  key_length_i,
  input  logic [DATA_W-1:0] data_in_i,
  output logic              push_o,
  output item_t             item_o,
  input  q_status_t         q_status_i
);

  front_state_e state_q, state_d;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [7:0]        cur_byte;
  logic              accept;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  // Saturate the length and zero the bytes past it
  always_comb begin
    len_d = (key_length_i > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_length_i;
    key_d = '0;
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      if (LEN_W'(b) < len_d) begin
        key_d[8*b +: 8] = key_bytes_i[8*b +: 8];
      end
    end
  end

  assign cur_byte = key_q[8*cnt_q[BYTE_IDX_W-1:0] +: 8];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          hash_d  = FNV_BASIS;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_q == len_q) begin
          // hash complete: hand off once the queue has room
          if (!q_status_i.full) begin
            push_o  = 1'b1;
            state_d = F_IDLE;
          end
        end else begin
          hash_d = HASH_W'((hash_q ^ {24'b0, cur_byte}) * FNV_PRIME);
          cnt_d  = cnt_q + 1'b1;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    hash_q <= hash_d;
    if (accept) begin
      op_q   <= req_type_i;
      key_q  <= key_d;
      len_q  <= len_d;
      data_q <= data_in_i;
    end
  end

  assign item_o.op   = op_q;
  assign item_o.key  = key_q;
  assign item_o.len  = len_q;
  assign item_o.data = data_q;
  assign item_o.home = hash_q[SLOT_W-1:0];

endmodule

FILE: rtl/fnvht_queue.sv
module fnvht_queue import fnvht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     head_o,
  output q_status_t status_o
);

  item_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/fnvht_back.sv
module fnvht_back import fnvht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              head_i,
  input  q_status_t          q_status_i,
  output logic               pop_o,
  input  logic [LIMIT_W-1:0] entry_limit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [DATA_W-1:0]  data_out_o
);

  back_state_e state_q, state_d;

  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] step_q, step_d;

  logic [TABLE_SLOTS-1:0] used_q;
  logic [CNT_W-1:0]       count_q;

  logic                  res_valid_q;
  logic [STAT_W-1:0]     res_status_q, res_status_d;
  logic [DATA_W-1:0]     res_data_q, res_data_d;
  logic                  res_free, res_load;

  logic [SLOT_KEY_W-1:0] slot_key_rd;
  logic [DATA_W-1:0]     slot_val_rd;
  logic                  key_we, val_we;

  logic used_here, match, last_step, decide, at_limit;

  assign res_free  = !res_valid_q || !out_stall_i;
  assign used_here = used_q[idx_q];
  assign match     = used_here && (slot_key_rd == {len_q, key_q});
  assign last_step = (step_q == SLOT_W'(TABLE_SLOTS - 1));
  assign decide    = !used_here || match || last_step;
  assign at_limit  = (32'(count_q) >= 32'(entry_limit_i)) ||
                     (32'(count_q) >= 32'(TABLE_SLOTS - 1)) ||
                     used_here;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    len_d        = len_q;
    data_d       = data_q;
    idx_d        = idx_q;
    step_d       = step_q;
    pop_o        = 1'b0;
    res_load     = 1'b0;
    res_status_d = ST_NOT_FOUND;
    res_data_d   = '0;
    key_we       = 1'b0;
    val_we       = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          case (head_i.op)
            REQ_GET, REQ_DEFINE, REQ_ASSIGN: begin
              pop_o   = 1'b1;
              op_d    = head_i.op;
              key_d   = head_i.key;
              len_d   = head_i.len;
              data_d  = head_i.data;
              idx_d   = head_i.home;
              step_d  = '0;
              state_d = B_PROBE;
            end
            default: begin
              // reserved code: answer not found, touch nothing
              if (res_free) begin
                pop_o    = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      B_PROBE: begin
        if (!decide) begin
          idx_d  = idx_q + 1'b1;
          step_d = step_q + 1'b1;
        end else if (res_free) begin
          res_load = 1'b1;
          state_d  = B_IDLE;
          if (match) begin
            res_status_d = ST_OK;
            if (op_q == REQ_GET) begin
              res_data_d = slot_val_rd;
            end else begin
              val_we = 1'b1;
            end
          end else if (op_q == REQ_DEFINE) begin
            if (at_limit) begin
              res_status_d = ST_FULL;
            end else begin
              res_status_d = ST_OK;
              key_we       = 1'b1;
              val_we       = 1'b1;
            end
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (key_we) begin
        used_q[idx_q] <= 1'b1;
        count_q       <= count_q + 1'b1;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    len_q  <= len_d;
    data_q <= data_d;
    idx_q  <= idx_d;
    step_q <= step_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
    end
  end

  // Both stores are read at the next slot so the word is ready when probing it
  fnvht_ram #(
    .WIDTH (SLOT_KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (idx_q),
    .wdata_i ({len_q, key_q}),
    .raddr_i (idx_d),
    .rdata_o (slot_key_rd)
  );

  fnvht_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_SLOTS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx_q),
    .wdata_i (data_q),
    .raddr_i (idx_d),
    .rdata_o (slot_val_rd)
  );

  assign out_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign data_out_o  = res_data_q;

endmodule

FILE: rtl/fnv1a_linear_probe_hash_table.sv
// Key-value table, 64 slots, FNV-1a hashed keys of up to 8 bytes, linear probing.
// Request channel: in_valid_i / in_stall_o with req_type_i (get, define, assign),
// key_bytes_i, key_length_i and data_in_i. Result channel: out_valid_o /
// out_stall_i with status_o (ok, not found, full) and data_out_o; exactly one
// result per request, in request order.
// The front end takes a request, then hashes one key byte per cycle through a
// 32-bit multiply by the FNV prime, with the length saturated at 8, and takes no
// new request until it has handed the slot index and request to a two-entry queue.
// The probe engine reads one slot per cycle from the key and value RAMs (registered
// read) and takes no new request until it has loaded the result of the last one.
// Without output stalls, the sustained rate is set by the slower of the hash loop
// and the probe loop.
// The entry_limit register (APB, address 0, reset 48) caps the occupied slots;
// write it only while the block is idle.
// Reset empties the table (per-slot used bits and the entry count clear at once)
// and no clearing pass is needed. While out_stall_i holds the result, the engine
// waits and the queue and front end keep filling until they are full.
module fnv1a_linear_probe_hash_table import fnvht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    req_type_i,
  input  logic [KEY_W-1:0]   key_bytes_i,
  input  logic [LEN_W-1:0]   key_length_i,
  input  logic [DATA_W-1:0]  data_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [DATA_W-1:0]  data_out_o
);

  logic [LIMIT_W-1:0] entry_limit_q;
  logic               reg_sel;
  logic               push;
  logic               pop;
  item_t              push_item;
  item_t              head_item;
  q_status_t          q_status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_ENTRY_LIMIT);
  assign prdata  = reg_sel ? PDATA_W'(entry_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      entry_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  fnvht_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .key_bytes_i  (key_bytes_i),
    .key_length_i (key_length_i),
    .data_in_i    (data_in_i),
    .push_o       (push),
    .item_o       (push_item),
    .q_status_i   (q_status)
  );

  fnvht_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  fnvht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_item),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .entry_limit_i (entry_limit_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o)
  );

endmodule
